// ===== sv/uer_pkg.sv =====
// ---------------------------------------------------------------------------
// uer_pkg: shared types and constants for the ultrasonic echo ranger
// Phase encoding, status codes and register indexes.
// ---------------------------------------------------------------------------
package uer_pkg;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_SETTLE  = 3'd1,
        PH_PULSE   = 3'd2,
        PH_RISE    = 3'd3,
        PH_MEASURE = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_START_TIMEOUT = 2'd1,
        ST_END_TIMEOUT   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        REG_SETTLE_TICKS = 2'd0,
        REG_PULSE_TICKS  = 2'd1,
        REG_WAIT_LIMIT   = 2'd2,
        REG_SCALE_Q16    = 2'd3
    } t_reg_index;

    localparam logic [7:0]  SETTLE_RESET = 8'd2;
    localparam logic [7:0]  PULSE_RESET  = 8'd10;
    localparam logic [16:0] WAIT_RESET   = 17'd100000;
    localparam logic [15:0] SCALE_RESET  = 16'd1114;

    localparam logic [15:0] ECHO_OUT_MAX = 16'hFFFF;
    localparam logic [23:0] DIST_MAX     = 24'hFFFFFF;

endpackage

// ===== sv/ultrasonic_echo_ranger_unit.sv =====
// ---------------------------------------------------------------------------
// ultrasonic_echo_ranger_unit: trigger/echo ranging controller
// The result beat of an accepted input beat is registered and valid in the next cycle.
// Throughput: one beat per cycle; a new beat is taken while the result
// register drains, so the only stall is downstream back-pressure.
// Reset (i_rst_n low, synchronous): phase idle, counters and last result
// cleared, configuration back to its defaults, no result pending.
// ---------------------------------------------------------------------------
module ultrasonic_echo_ranger_unit
    import uer_pkg::*;
#(
    parameter int ECHO_WIDTH = 16,
    parameter int WAIT_WIDTH = 17
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] tick, [1] start_req, [2] echo_level, [7:3] zero
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // [0] trigger_level, [1] busy_res, [2] done_res,
                                        // [4:3] status, [28:5] distance_q8,
                                        // [44:29] echo_ticks, [47:45] zero
);

    // Compare width covering both the phase counter and the 17-bit limit.
    localparam int CMP_W  = (WAIT_WIDTH > 17) ? WAIT_WIDTH : 17;
    // Echo count widened for the 16-bit saturation test.
    localparam int EXT_W  = (ECHO_WIDTH > 16) ? ECHO_WIDTH : 16;
    // Product of echo length and Q16 scale, then after the Q8 shift.
    localparam int PROD_W = ECHO_WIDTH + 16;
    localparam int SHR_W  = PROD_W - 8;
    localparam int DST_W  = (SHR_W > 24) ? SHR_W : 24;

    // Configuration registers
    logic [7:0]  r_settle_ticks;
    logic [7:0]  r_pulse_ticks;
    logic [16:0] r_wait_limit;
    logic [15:0] r_scale_q16;

    // Measurement state
    t_phase                  r_phase,       n_phase;
    logic [WAIT_WIDTH-1:0]   r_phase_count, n_phase_count;
    logic [ECHO_WIDTH-1:0]   r_echo_count,  n_echo_count;
    logic [1:0]              r_status,      n_status;
    logic [23:0]             r_distance,    n_distance;
    logic                    n_done;

    // Result register
    logic        r_out_valid;
    logic [47:0] r_out_data, n_out_data;

    logic w_accept;
    logic w_tick, w_start, w_echo;
    logic [WAIT_WIDTH-1:0] w_count_inc;
    logic [CMP_W-1:0]      w_inc_ext;
    logic [CMP_W-1:0]      w_cur_ext;
    logic [CMP_W-1:0]      w_wait_ext;
    logic [7:0]            w_lim;
    logic [PROD_W-1:0]     w_product;
    logic [DST_W-1:0]      w_dist_ext;
    logic [23:0]           w_dist_sat;
    logic [EXT_W-1:0]      w_echo_ext;
    logic [15:0]           w_echo_sat;

    // Configuration is taken every cycle; the host must write only while idle (not enforced here).
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_ticks <= SETTLE_RESET;
            r_pulse_ticks  <= PULSE_RESET;
            r_wait_limit   <= WAIT_RESET;
            r_scale_q16    <= SCALE_RESET;
        end else if (i_cfg_valid) begin
            case (t_reg_index'(i_cfg_index))
                REG_SETTLE_TICKS: r_settle_ticks <= i_cfg_data[7:0];
                REG_PULSE_TICKS:  r_pulse_ticks  <= i_cfg_data[7:0];
                REG_WAIT_LIMIT:   r_wait_limit   <= i_cfg_data[16:0];
                REG_SCALE_Q16:    r_scale_q16    <= i_cfg_data[15:0];
                default:          r_scale_q16    <= r_scale_q16;
            endcase
        end
    end

    // Take a new beat whenever the result register is empty or draining.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_tick  = s_axis_tdata[0];
    assign w_start = s_axis_tdata[1];
    assign w_echo  = s_axis_tdata[2];

    // Shared counter increment and the widened operands for the limit tests.
    assign w_count_inc = r_phase_count + WAIT_WIDTH'(1);
    assign w_inc_ext   = CMP_W'(w_count_inc);
    assign w_cur_ext   = CMP_W'(r_phase_count);
    assign w_wait_ext  = CMP_W'(r_wait_limit);
    assign w_lim       = (r_phase == PH_SETTLE) ? r_settle_ticks : r_pulse_ticks;

    // Distance: echo length times Q16 scale, down to Q8, clamp at 24 bits.
    assign w_product  = PROD_W'(r_echo_count) * PROD_W'(r_scale_q16);
    assign w_dist_ext = DST_W'(w_product[PROD_W-1:8]);
    assign w_dist_sat = (w_dist_ext > DST_W'(DIST_MAX)) ? DIST_MAX : w_dist_ext[23:0];

    // Next-state logic for one accepted beat.
    always_comb begin
        n_phase       = r_phase;
        n_phase_count = r_phase_count;
        n_echo_count  = r_echo_count;
        n_status      = r_status;
        n_distance    = r_distance;
        n_done        = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                if (w_start) begin
                    n_phase       = PH_SETTLE;
                    n_phase_count = '0;
                end
            end
            PH_SETTLE, PH_PULSE: begin
                // advance on a tick, move on once the count reaches the limit
                if ((w_tick ? w_inc_ext : w_cur_ext) >= CMP_W'(w_lim)) begin
                    n_phase       = (r_phase == PH_SETTLE) ? PH_PULSE : PH_RISE;
                    n_phase_count = '0;
                end else if (w_tick) begin
                    n_phase_count = w_count_inc;
                end
            end
            PH_RISE: begin
                if (w_echo) begin
                    n_phase       = PH_MEASURE;
                    n_phase_count = '0;
                    n_echo_count  = '0;
                end else if (w_tick) begin
                    n_phase_count = w_count_inc;
                    if (w_inc_ext >= w_wait_ext) begin
                        n_phase       = PH_IDLE;
                        n_phase_count = '0;
                        n_status      = ST_START_TIMEOUT;
                        n_distance    = '0;
                        n_done        = 1'b1;
                    end
                end
            end
            PH_MEASURE: begin
                if (!w_echo) begin
                    n_phase       = PH_IDLE;
                    n_phase_count = '0;
                    n_status      = ST_OK;
                    n_distance    = w_dist_sat;
                    n_done        = 1'b1;
                end else if (w_tick) begin
                    // hold the echo count at its ceiling
                    if (r_echo_count != '1) begin
                        n_echo_count = r_echo_count + ECHO_WIDTH'(1);
                    end
                    n_phase_count = w_count_inc;
                    if (w_inc_ext >= w_wait_ext) begin
                        n_phase       = PH_IDLE;
                        n_phase_count = '0;
                        n_status      = ST_END_TIMEOUT;
                        n_distance    = '0;
                        n_done        = 1'b1;
                    end
                end
            end
            default: begin
                n_phase       = PH_IDLE;
                n_phase_count = '0;
            end
        endcase
    end

    // Result fields describe the state after the step.
    assign w_echo_ext = EXT_W'(n_echo_count);
    assign w_echo_sat = (w_echo_ext > EXT_W'(ECHO_OUT_MAX)) ? ECHO_OUT_MAX
                                                            : w_echo_ext[15:0];

    always_comb begin
        n_out_data        = '0;
        n_out_data[0]     = (n_phase == PH_PULSE);
        n_out_data[1]     = (n_phase != PH_IDLE);
        n_out_data[2]     = n_done;
        n_out_data[4:3]   = n_status;
        n_out_data[28:5]  = n_distance;
        n_out_data[44:29] = w_echo_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_phase_count <= '0;
            r_echo_count  <= '0;
            r_status      <= ST_OK;
            r_distance    <= '0;
        end else if (w_accept) begin
            r_phase       <= n_phase;
            r_phase_count <= n_phase_count;
            r_echo_count  <= n_echo_count;
            r_status      <= n_status;
            r_distance    <= n_distance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload register: load on accept, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== tb/sv/tb_ultrasonic_echo_ranger_unit.sv =====
// ---------------------------------------------------------------------------
// tb_ultrasonic_echo_ranger_unit: self-checking bench for the echo ranger
// Streams one sample beat per clock (tick, start request, echo level) into
// the unit and checks every result beat against a cycle model of the
// trigger/echo sequence. Sessions are separated by register writes, and
// cover the low and high register extremes and timeouts on both echo edges.
// Both stream sides idle and stall at random.
// ---------------------------------------------------------------------------
module tb_ultrasonic_echo_ranger_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import uer_pkg::*;

    // Cycles with no beat on any channel before the run is declared hung.
    // The sender only pauses between bursts and the receiver is ready at least
    // 40% of the time, so a healthy run never gets near this.
    localparam int QUIET_LIMIT = 2000;
    // Idle cycles after the last result before closing the run
    localparam int TAIL_CYCLES = 20;

    // one sample beat, tick in bit 0
    typedef struct packed {
        logic echo;
        logic start;
        logic tick;
    } t_sample;

    // one result beat, trigger level in bit 0
    typedef struct packed {
        logic [15:0] echo_ticks;
        logic [23:0] distance_q8;
        t_status     status;
        logic        done;
        logic        busy;
        logic        trigger;
    } t_reading;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index   = '0;
    logic [31:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [0] tick, [1] start_req, [2] echo_level, [7:3] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;         // [0] trigger_level, [1] busy_res, [2] done_res,
                                       // [4:3] status, [28:5] distance_q8,
                                       // [44:29] echo_ticks, [47:45] zero

    ultrasonic_echo_ranger_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // -----------------------------------------------------------------------
    // Ranging model: own copy of registers and sequencer state
    // -----------------------------------------------------------------------
    logic [7:0]  cfg_settle = SETTLE_RESET;
    logic [7:0]  cfg_pulse  = PULSE_RESET;
    logic [16:0] cfg_wait   = WAIT_RESET;
    logic [15:0] cfg_scale  = SCALE_RESET;

    t_phase      pr_phase  = PH_IDLE;
    logic [16:0] pr_count  = '0;
    logic [15:0] pr_echo   = '0;
    t_status     pr_status = ST_OK;
    logic [23:0] pr_dist   = '0;

    t_sample  pending_samples[$];     // filled by the sequence, drained by the driver
    t_reading expected_readings[$];   // one per accepted sample beat

    int unsigned beats_queued = 0;    // sample beats handed to the driver
    int unsigned beats_taken  = 0;    // sample beats accepted by the unit
    int unsigned mismatches   = 0;
    bit          in_taken     = 1'b0; // sample beat accepted at the last rising edge

    // End a measurement: latch status and distance, drop back to idle
    task automatic close_measurement(input t_status st, input logic [23:0] distance);
        pr_status = st;
        pr_dist   = distance;
        pr_phase  = PH_IDLE;
        pr_count  = '0;
    endtask

    // Advance the sequencer by one sample and form the result beat it gives
    task automatic advance_ranger(input t_sample s, output t_reading r);
        logic [7:0]  lim;
        logic [39:0] product;
        logic        done;
        done = 1'b0;
        case (pr_phase)
            PH_IDLE: begin
                if (s.start) begin
                    pr_phase = PH_SETTLE;
                    pr_count = '0;
                end
            end
            PH_SETTLE, PH_PULSE: begin
                lim = (pr_phase == PH_SETTLE) ? cfg_settle : cfg_pulse;
                if (s.tick)
                    pr_count = pr_count + 17'd1;
                // with a zero limit the phase still ends only on the following sample beat
                if (pr_count >= {9'd0, lim}) begin
                    if (pr_phase == PH_SETTLE)
                        pr_phase = PH_PULSE;
                    else
                        pr_phase = PH_RISE;
                    pr_count = '0;
                end
            end
            PH_RISE: begin
                if (s.echo) begin
                    pr_phase = PH_MEASURE;
                    pr_count = '0;
                    pr_echo  = '0;
                end else if (s.tick) begin
                    pr_count = pr_count + 17'd1;
                    if (pr_count >= cfg_wait) begin
                        close_measurement(ST_START_TIMEOUT, '0);
                        done = 1'b1;
                    end
                end
            end
            PH_MEASURE: begin
                if (!s.echo) begin
                    // Q16 scale times ticks, back to Q8, clamp to 24 bits
                    product = ({24'd0, pr_echo} * {24'd0, cfg_scale}) >> 8;
                    close_measurement(ST_OK,
                        (product > {16'd0, DIST_MAX}) ? DIST_MAX : product[23:0]);
                    done = 1'b1;
                end else if (s.tick) begin
                    if (pr_echo != ECHO_OUT_MAX)
                        pr_echo = pr_echo + 16'd1;
                    pr_count = pr_count + 17'd1;
                    // echo length is kept on an end timeout
                    if (pr_count >= cfg_wait) begin
                        close_measurement(ST_END_TIMEOUT, '0);
                        done = 1'b1;
                    end
                end
            end
            default: begin
                pr_phase = PH_IDLE;
                pr_count = '0;
            end
        endcase
        r.trigger     = (pr_phase == PH_PULSE);
        r.busy        = (pr_phase != PH_IDLE);
        r.done        = done;
        r.status      = pr_status;
        r.distance_q8 = pr_dist;
        r.echo_ticks  = pr_echo;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("reading mismatch at %0t: %s expected 0x%0h got 0x%0h",
                         $realtime, name, want, got);
        end
    endtask

    // -----------------------------------------------------------------------
    // Monitor: check result beats, predict from accepted sample beats
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_reading got;
        t_reading want;
        if (!i_rst_n) begin
            in_taken = 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_reading'(m_axis_tdata[44:0]);
                if (expected_readings.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("reading mismatch at %0t: result beat 0x%0h with none due",
                                 $realtime, m_axis_tdata);
                end else begin
                    want = expected_readings.pop_front();
                    compare_field("trigger_level", want.trigger, got.trigger);
                    compare_field("busy_res", want.busy, got.busy);
                    compare_field("done_res", want.done, got.done);
                    compare_field("status", want.status, got.status);
                    compare_field("distance_q8", want.distance_q8, got.distance_q8);
                    compare_field("echo_ticks", want.echo_ticks, got.echo_ticks);
                end
            end
            in_taken = s_axis_tvalid && s_axis_tready;
            if (in_taken) begin
                advance_ranger(t_sample'(s_axis_tdata[2:0]), want);
                expected_readings.push_back(want);
                beats_taken++;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Driver: bursts of sample beats with random gaps, changes on falling edge
    // -----------------------------------------------------------------------
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (gap_left != 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
                s_axis_tdata  <= {5'd0, pending_samples.pop_front()};
                s_axis_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    // new burst; about a third run straight on with no gap
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 99) < 35) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Receiver: stall pattern switches between always ready, random, periodic
    // -----------------------------------------------------------------------
    int unsigned ready_mode = 0;
    int unsigned ready_left = 0;
    int unsigned ready_beat = 0;

    always @(negedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            ready_left = $urandom_range(20, 200);
        end
        ready_left--;
        ready_beat++;
        case (ready_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 99) < 60);
            default: m_axis_tready <= ((ready_beat % 7) > 1);   // periodic: low when ready_beat mod 7 is 0 or 1
        endcase
    end

    // -----------------------------------------------------------------------
    // Watchdog: give up after a long stretch with no beat anywhere
    // -----------------------------------------------------------------------
    logic        any_beat;
    int unsigned quiet_cycles = 0;

    assign any_beat = (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (i_cfg_valid && o_cfg_ready);

    always @(posedge i_clk) begin
        if (!i_rst_n || any_beat)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("ultrasonic_echo_ranger_unit verification failed");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Sequence helpers
    // -----------------------------------------------------------------------
    function automatic bit chance(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    task automatic push_sample(input bit tick, input bit start, input bit echo);
        t_sample s;
        s.tick  = tick;
        s.start = start;
        s.echo  = echo;
        pending_samples.push_back(s);
        beats_queued++;
    endtask

    // One ranging attempt: start beat, echo low, echo high, echo low again.
    // Ticks and stray start requests are sprinkled at the given rates.
    task automatic queue_ranging(input int pre, input int high_len, input int tail,
                                 input int tick_pct, input int start_pct);
        push_sample(chance(tick_pct), 1'b1, chance(50));
        repeat (pre)      push_sample(chance(tick_pct), chance(start_pct), 1'b0);
        repeat (high_len) push_sample(chance(tick_pct), chance(start_pct), 1'b1);
        repeat (tail)     push_sample(chance(tick_pct), chance(start_pct), 1'b0);
    endtask

    // Attempt sized from the current registers: mostly clean echoes, some
    // arriving during the trigger, some missing or stuck high past the limit
    task automatic queue_random_run();
        int pct;
        int lead;
        int pre;
        int high_len;
        pct  = chance(35) ? 100 : $urandom_range(25, 90);
        lead = (int'(cfg_settle) + int'(cfg_pulse) + 2) * 100 / pct;
        case ($urandom_range(0, 5))
            0:       pre = $urandom_range(0, lead);
            1:       pre = lead + (int'(cfg_wait) + 4) * 100 / pct;
            default: pre = lead + $urandom_range(0, int'(cfg_wait) * 50 / pct);
        endcase
        if (chance(20))
            high_len = (int'(cfg_wait) + 4) * 100 / pct;
        else
            high_len = $urandom_range(0, int'(cfg_wait) * 80 / pct);
        queue_ranging(pre, high_len, $urandom_range(1, 3), pct, 5);
    endtask

    // Hold until the driver is empty and every result beat has come back
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (beats_taken != beats_queued || expected_readings.size() != 0);
    endtask

    // Drain, then feed echo-low ticks until the sequencer is back to idle
    task automatic settle_to_idle();
        wait_drained();
        while (pr_phase != PH_IDLE) begin
            repeat (16) push_sample(1'b1, 1'b0, 1'b0);
            wait_drained();
        end
    endtask

    task automatic write_reg(input t_reg_index idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            REG_SETTLE_TICKS: cfg_settle = value[7:0];
            REG_PULSE_TICKS:  cfg_pulse  = value[7:0];
            REG_WAIT_LIMIT:   cfg_wait   = value[16:0];
            default:          cfg_scale  = value[15:0];
        endcase
    endtask

    // Registers only change with the unit idle and nothing in flight
    task automatic apply_settings(input int settle, input int pulse, input int limit,
                                  input int scale);
        settle_to_idle();
        write_reg(REG_SETTLE_TICKS, settle);
        write_reg(REG_PULSE_TICKS, pulse);
        write_reg(REG_WAIT_LIMIT, limit);
        write_reg(REG_SCALE_Q16, scale);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------
    initial begin
        int unsigned mark;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset registers: idle noise, then a clean measurement with a
        // start request while busy (ignored)
        push_sample(1'b0, 1'b0, 1'b0);
        push_sample(1'b1, 1'b0, 1'b1);
        push_sample(1'b0, 1'b0, 1'b1);
        push_sample(1'b1, 1'b0, 1'b0);
        queue_ranging(14, 6, 1, 100, 30);

        // Low extremes: zero settle, one-tick pulse, one-tick wait, zero scale.
        // Rise timeouts, a pulse held with no ticks, and an end timeout.
        apply_settings(0, 1, 1, 0);
        queue_ranging(4, 0, 1, 100, 0);
        queue_ranging(3, 4, 1, 100, 0);
        queue_ranging(3, 3, 1, 0, 0);
        settle_to_idle();
        queue_ranging(2, 5, 1, 100, 0);

        // High extremes: longest trigger, widest wait, full scale, with a
        // short clean echo once the trigger is done.
        apply_settings(255, 255, 131071, 65535);
        queue_ranging(520, 40, 2, 100, 2);

        // Random sessions with short waits so timeouts are frequent
        repeat (4) begin
            apply_settings($urandom_range(0, 6), $urandom_range(1, 6),
                           $urandom_range(1, 30), $urandom_range(0, 65535));
            mark = beats_queued;
            while (beats_queued - mark < 60) begin
                if (chance(80)) begin
                    queue_random_run();
                end else begin
                    repeat ($urandom_range(1, 8))
                        push_sample(chance(50), chance(20), chance(50));
                end
            end
        end

        settle_to_idle();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0)
            $display("ultrasonic_echo_ranger_unit verification clean");
        else
            $display("ultrasonic_echo_ranger_unit verification failed");
        $finish;
    end

endmodule

// ===== ultrasonic_echo_ranger_unit.f =====
sv/uer_pkg.sv
sv/ultrasonic_echo_ranger_unit.sv
tb/sv/tb_ultrasonic_echo_ranger_unit.sv
